FILE: src/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the cursor line editor buffer.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CNT_W        = 7;
  localparam int SYM_W        = 8;
  localparam int OP_W         = 3;
  localparam int ST_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_DUMP   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

FILE: src/cle_stack_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_stack_ram
// One stack store: single write port, one registered read port.
// ----------------------------------------------------------------------------
module cle_stack_ram import cle_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  ram_ctl_t         ctl,
  input  logic [AW-1:0]    wr_addr,
  input  logic [SYM_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [SYM_W-1:0] rd_data
);

  logic [SYM_W-1:0] mem [DEPTH];
  logic [SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/cle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ctrl
// Operation sequencer: stack counts, store read/modify/write, dump walk and
// result register.
// ----------------------------------------------------------------------------
module cle_ctrl import cle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [SYM_W-1:0] in_symbol,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_symbol_valid,
  output logic             out_last,
  output logic [ST_W-1:0]  out_status,
  output logic [CNT_W-1:0] out_text_length,
  output logic [CNT_W-1:0] out_cursor_position,
  output ram_ctl_t         bef_ctl,
  output logic [AW-1:0]    bef_wr_addr,
  output logic [SYM_W-1:0] bef_wr_data,
  output logic [AW-1:0]    bef_rd_addr,
  input  logic [SYM_W-1:0] bef_rd_data,
  output ram_ctl_t         aft_ctl,
  output logic [AW-1:0]    aft_wr_addr,
  output logic [SYM_W-1:0] aft_wr_data,
  output logic [AW-1:0]    aft_rd_addr,
  input  logic [SYM_W-1:0] aft_rd_data
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_EXEC    = 4'b0010,
    S_DUMP_RD = 4'b0100,
    S_DUMP_WR = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [SYM_W-1:0] sym_r;
  logic [CNT_W-1:0] bc_r, bc_nxt, ac_r, ac_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             sel_after_r, sel_after_nxt;

  logic [SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  logic             out_symbol_valid_r, out_symbol_valid_nxt;
  logic             out_last_r, out_last_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_len_r, out_len_nxt;
  logic [CNT_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_xfer;
  logic             out_free;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] k_inc;
  logic [CNT_W-1:0] aft_dump_idx;
  logic             load;

  // edit decode
  status_t          ed_status;
  logic [CNT_W-1:0] ed_bc, ed_ac;
  logic             ed_bef_we, ed_aft_we;
  logic [SYM_W-1:0] ed_bef_wd;

  assign in_xfer      = in_valid && (state_r == S_IDLE);
  assign in_stall     = (state_r != S_IDLE);
  assign out_free     = !out_valid_r || !out_stall;
  assign total        = bc_r + ac_r;
  assign k_inc        = k_r + CNT_W'(1);
  assign aft_dump_idx = total - k_inc;

  always_comb begin
    ed_status = ST_DONE;
    ed_bc     = bc_r;
    ed_ac     = ac_r;
    ed_bef_we = 1'b0;
    ed_aft_we = 1'b0;
    ed_bef_wd = sym_r;
    case (op_r)
      OP_LEFT: begin
        if (bc_r == '0 || ac_r >= CAP) begin
          ed_status = ST_IGNORED;
        end else begin
          ed_aft_we = 1'b1;
          ed_bc     = bc_r - CNT_W'(1);
          ed_ac     = ac_r + CNT_W'(1);
        end
      end
      OP_RIGHT: begin
        if (ac_r == '0 || bc_r >= CAP) begin
          ed_status = ST_IGNORED;
        end else begin
          ed_bef_we = 1'b1;
          ed_bef_wd = aft_rd_data;
          ed_bc     = bc_r + CNT_W'(1);
          ed_ac     = ac_r - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (total >= CAP) begin
          ed_status = ST_FULL;
        end else begin
          ed_bef_we = 1'b1;
          ed_bc     = bc_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (bc_r == '0) begin
          ed_status = ST_IGNORED;
        end else begin
          ed_bc = bc_r - CNT_W'(1);
        end
      end
      OP_DUMP: ed_status = ST_DONE;
      default: ed_status = ST_IGNORED;
    endcase
  end

  always_comb begin
    state_nxt            = state_r;
    bc_nxt               = bc_r;
    ac_nxt               = ac_r;
    k_nxt                = k_r;
    sel_after_nxt        = sel_after_r;
    load                 = 1'b0;
    out_symbol_nxt       = out_symbol_r;
    out_symbol_valid_nxt = out_symbol_valid_r;
    out_last_nxt         = out_last_r;
    out_status_nxt       = out_status_r;
    out_len_nxt          = out_len_r;
    out_pos_nxt          = out_pos_r;

    bef_ctl      = '0;
    aft_ctl      = '0;
    bef_rd_addr  = bc_r[AW-1:0] - AW'(1);
    aft_rd_addr  = ac_r[AW-1:0] - AW'(1);
    bef_wr_addr  = bc_r[AW-1:0];
    aft_wr_addr  = ac_r[AW-1:0];
    bef_wr_data  = ed_bef_wd;
    aft_wr_data  = bef_rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // fetch the character that a move carries across the gap
          bef_ctl.rd_en = (op_t'(in_operation) == OP_LEFT);
          aft_ctl.rd_en = (op_t'(in_operation) == OP_RIGHT);
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_DUMP && total != '0) begin
          k_nxt     = '0;
          state_nxt = S_DUMP_RD;
        end else if (out_free) begin
          bef_ctl.wr_en        = ed_bef_we;
          aft_ctl.wr_en        = ed_aft_we;
          bc_nxt               = ed_bc;
          ac_nxt               = ed_ac;
          load                 = 1'b1;
          out_symbol_nxt       = '0;
          out_symbol_valid_nxt = 1'b0;
          out_last_nxt         = 1'b1;
          out_status_nxt       = ed_status;
          out_len_nxt          = ed_bc + ed_ac;
          out_pos_nxt          = ed_bc;
          state_nxt            = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        // left part in order, then right part from its top down
        sel_after_nxt = (k_r >= bc_r);
        bef_rd_addr   = k_r[AW-1:0];
        aft_rd_addr   = aft_dump_idx[AW-1:0];
        bef_ctl.rd_en = (k_r < bc_r);
        aft_ctl.rd_en = (k_r >= bc_r);
        state_nxt     = S_DUMP_WR;
      end
      S_DUMP_WR: begin
        if (out_free) begin
          load                 = 1'b1;
          out_symbol_nxt       = sel_after_r ? aft_rd_data : bef_rd_data;
          out_symbol_valid_nxt = 1'b1;
          out_last_nxt         = (k_inc == total);
          out_status_nxt       = ST_DONE;
          out_len_nxt          = total;
          out_pos_nxt          = bc_r;
          k_nxt                = k_inc;
          state_nxt            = (k_inc == total) ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bc_r        <= '0;
      ac_r        <= '0;
      k_r         <= '0;
      sel_after_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bc_r        <= bc_nxt;
      ac_r        <= ac_nxt;
      k_r         <= k_nxt;
      sel_after_r <= sel_after_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= op_t'(in_operation);
      sym_r <= in_symbol;
    end
    out_symbol_r       <= out_symbol_nxt;
    out_symbol_valid_r <= out_symbol_valid_nxt;
    out_last_r         <= out_last_nxt;
    out_status_r       <= out_status_nxt;
    out_len_r          <= out_len_nxt;
    out_pos_r          <= out_pos_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_symbol          = out_symbol_r;
  assign out_symbol_valid    = out_symbol_valid_r;
  assign out_last            = out_last_r;
  assign out_status          = out_status_r;
  assign out_text_length     = out_len_r;
  assign out_cursor_position = out_pos_r;

endmodule

FILE: src/cursor_line_editor_buffer.sv
`timescale 1ns / 1ps
// An edit result is registered from S_EXEC, after its input transfer, once the output is free.
// The input stalls until the edit is done (one store read, then write-back).
// A dump yields its characters one at a time, each from one registered store read
// in S_DUMP_RD that is then registered for output in S_DUMP_WR.
// Reset clears FSM state, stack counts and out_valid; stores need no clearing.
// ----------------------------------------------------------------------------
// cursor_line_editor_buffer
// Line editor with a cursor, held as a gap buffer of two stacks in RAM.
// ----------------------------------------------------------------------------
module cursor_line_editor_buffer import cle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [SYM_W-1:0] in_symbol,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_symbol_valid,
  output logic             out_last,
  output logic [ST_W-1:0]  out_status,
  output logic [CNT_W-1:0] out_text_length,
  output logic [CNT_W-1:0] out_cursor_position
);

  localparam int AW = $clog2(CAPACITY);

  ram_ctl_t         bef_ctl, aft_ctl;
  logic [AW-1:0]    bef_wr_addr, bef_rd_addr, aft_wr_addr, aft_rd_addr;
  logic [SYM_W-1:0] bef_wr_data, bef_rd_data, aft_wr_data, aft_rd_data;

  cle_stack_ram #(.DEPTH(CAPACITY), .AW(AW)) u_bef_ram (
    .clk     (clk),
    .ctl     (bef_ctl),
    .wr_addr (bef_wr_addr),
    .wr_data (bef_wr_data),
    .rd_addr (bef_rd_addr),
    .rd_data (bef_rd_data)
  );

  cle_stack_ram #(.DEPTH(CAPACITY), .AW(AW)) u_aft_ram (
    .clk     (clk),
    .ctl     (aft_ctl),
    .wr_addr (aft_wr_addr),
    .wr_data (aft_wr_data),
    .rd_addr (aft_rd_addr),
    .rd_data (aft_rd_data)
  );

  cle_ctrl #(.CAPACITY(CAPACITY), .AW(AW)) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_symbol           (in_symbol),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_symbol          (out_symbol),
    .out_symbol_valid    (out_symbol_valid),
    .out_last            (out_last),
    .out_status          (out_status),
    .out_text_length     (out_text_length),
    .out_cursor_position (out_cursor_position),
    .bef_ctl             (bef_ctl),
    .bef_wr_addr         (bef_wr_addr),
    .bef_wr_data         (bef_wr_data),
    .bef_rd_addr         (bef_rd_addr),
    .bef_rd_data         (bef_rd_data),
    .aft_ctl             (aft_ctl),
    .aft_wr_addr         (aft_wr_addr),
    .aft_wr_data         (aft_wr_data),
    .aft_rd_addr         (aft_rd_addr),
    .aft_rd_data         (aft_rd_data)
  );

endmodule

FILE: tb/sv/cursor_line_editor_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_editor_scoreboard
// Watches both channels of the line editor, tracks the gap buffer text on
// every accepted operation and checks each result transfer in order.
// ----------------------------------------------------------------------------
module cursor_line_editor_scoreboard import cle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [SYM_W-1:0] out_symbol,
  input  logic             out_symbol_valid,
  input  logic             out_last,
  input  logic [ST_W-1:0]  out_status,
  input  logic [CNT_W-1:0] out_text_length,
  input  logic [CNT_W-1:0] out_cursor_position,
  output int               mismatches,
  output int               outstanding,
  output int               results_checked
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             symbol_valid;
    logic             last;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] text_length;
    logic [CNT_W-1:0] cursor_position;
  } editor_result_t;

  // Text left of the cursor (first character at 0) and right of it (nearest on top)
  logic [SYM_W-1:0] head_chars [CAPACITY_DEF];
  logic [SYM_W-1:0] tail_chars [CAPACITY_DEF];
  int               head_len = 0;
  int               tail_len = 0;
  editor_result_t   due_results [$];
  int               miss_total = 0;
  int               checked_total = 0;

  task automatic push_result(input logic [SYM_W-1:0] sym, input logic sym_valid,
                             input logic lst, input status_t st);
    editor_result_t r;
    r.symbol          = sym;
    r.symbol_valid    = sym_valid;
    r.last            = lst;
    r.status          = st;
    r.text_length     = CNT_W'(head_len + tail_len);
    r.cursor_position = CNT_W'(head_len);
    due_results.push_back(r);
  endtask

  task automatic apply_operation(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    status_t st;
    int      total;
    int      k;
    st    = ST_DONE;
    total = head_len + tail_len;
    case (op)
      OP_LEFT: begin
        if (head_len == 0 || tail_len >= CAPACITY_DEF) begin
          st = ST_IGNORED;
        end else begin
          head_len--;
          tail_chars[tail_len] = head_chars[head_len];
          tail_len++;
        end
      end
      OP_RIGHT: begin
        if (tail_len == 0 || head_len >= CAPACITY_DEF) begin
          st = ST_IGNORED;
        end else begin
          tail_len--;
          head_chars[head_len] = tail_chars[tail_len];
          head_len++;
        end
      end
      OP_INSERT: begin
        if (total >= CAPACITY_DEF) begin
          st = ST_FULL;
        end else begin
          head_chars[head_len] = sym;
          head_len++;
        end
      end
      OP_DELETE: begin
        if (head_len == 0) st = ST_IGNORED;
        else head_len--;
      end
      OP_DUMP: begin
        if (total == 0) begin
          push_result('0, 1'b0, 1'b1, ST_DONE);
          return;
        end
        k = 0;
        for (int i = 0; i < head_len; i++) begin
          push_result(head_chars[i], 1'b1, k + 1 == total, ST_DONE);
          k++;
        end
        for (int i = tail_len; i > 0; i--) begin
          push_result(tail_chars[i-1], 1'b1, k + 1 == total, ST_DONE);
          k++;
        end
        return;
      end
      default: st = ST_IGNORED;
    endcase
    push_result('0, 1'b0, 1'b1, st);
  endtask

  task automatic check_result(input editor_result_t got);
    editor_result_t want;
    if (due_results.size() == 0) begin
      miss_total++;
      if (miss_total <= MAX_REPORTS)
        $display("%0t: result with nothing outstanding: sym=%02h sv=%0b last=%0b st=%0d len=%0d cur=%0d",
                 $realtime, got.symbol, got.symbol_valid, got.last, got.status,
                 got.text_length, got.cursor_position);
      return;
    end
    want = due_results.pop_front();
    checked_total++;
    if (got.symbol !== want.symbol || got.symbol_valid !== want.symbol_valid ||
        got.last !== want.last || got.status !== want.status ||
        got.text_length !== want.text_length ||
        got.cursor_position !== want.cursor_position) begin
      miss_total++;
      if (miss_total <= MAX_REPORTS) begin
        $display("%0t: mismatch on result %0d", $realtime, checked_total);
        $display("  expected sym=%02h sv=%0b last=%0b st=%0d len=%0d cur=%0d",
                 want.symbol, want.symbol_valid, want.last, want.status,
                 want.text_length, want.cursor_position);
        $display("  actual   sym=%02h sv=%0b last=%0b st=%0d len=%0d cur=%0d",
                 got.symbol, got.symbol_valid, got.last, got.status,
                 got.text_length, got.cursor_position);
      end
    end
  endtask

  always @(posedge clk) begin
    editor_result_t got;
    if (!rst_n) begin
      head_len = 0;
      tail_len = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.symbol          = out_symbol;
        got.symbol_valid    = out_symbol_valid;
        got.last            = out_last;
        got.status          = out_status;
        got.text_length     = out_text_length;
        got.cursor_position = out_cursor_position;
        check_result(got);
      end
      if (in_valid && !in_stall) apply_operation(in_operation, in_symbol);
    end
    outstanding     <= due_results.size();
    mismatches      <= miss_total;
    results_checked <= checked_total;
  end

endmodule

FILE: tb/sv/cursor_line_editor_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_editor_buffer_test
// Drives edit, cursor and dump operations into the line editor under three
// stall mixes, a long output hold and full-buffer bursts; the scoreboard
// predicts and checks every result.
// ----------------------------------------------------------------------------
module cursor_line_editor_buffer_test;
  import cle_pkg::*;

  localparam int              WATCHDOG_LIMIT   = 4000;
  localparam int              LONG_HOLD_CYCLES = 300;
  localparam int              SETTLE_CYCLES    = 8;
  localparam int              RESET_CYCLES     = 11;
  localparam int              PHASE_ITEMS      = 45;
  localparam logic [OP_W-1:0] OP_SPARE_LO      = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI      = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [OP_W-1:0]  in_operation;
  logic [SYM_W-1:0] in_symbol;
  logic             out_valid;
  logic             out_stall;
  logic [SYM_W-1:0] out_symbol;
  logic             out_symbol_valid;
  logic             out_last;
  logic [ST_W-1:0]  out_status;
  logic [CNT_W-1:0] out_text_length;
  logic [CNT_W-1:0] out_cursor_position;

  int mismatches;
  int outstanding;
  int results_checked;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int items_sent    = 0;
  int dumps_sent    = 0;
  int spare_sent    = 0;

  cursor_line_editor_buffer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_symbol           (in_symbol),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_symbol          (out_symbol),
    .out_symbol_valid    (out_symbol_valid),
    .out_last            (out_last),
    .out_status          (out_status),
    .out_text_length     (out_text_length),
    .out_cursor_position (out_cursor_position)
  );

  cursor_line_editor_scoreboard scoreboard (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_symbol           (in_symbol),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_symbol          (out_symbol),
    .out_symbol_valid    (out_symbol_valid),
    .out_last            (out_last),
    .out_status          (out_status),
    .out_text_length     (out_text_length),
    .out_cursor_position (out_cursor_position),
    .mismatches          (mismatches),
    .outstanding         (outstanding),
    .results_checked     (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stall, or a long hold when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_served++;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // End the run when no transfer happens on either channel for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, outstanding);
    $display("FAIL");
    $finish;
  end

  function automatic logic [SYM_W-1:0] rand_sym();
    return SYM_W'($urandom_range(0, 255));
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_symbol    <= sym;
    do @(posedge clk); while (in_stall);
    if (op >= OP_SPARE_LO) spare_sent++;
    else items_sent++;
    if (op == OP_DUMP) dumps_sent++;
  endtask

  // Pause the sender until every outstanding result has been transferred
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      send_op(OP_INSERT, rand_sym());
    else if (pick < 55) send_op(OP_LEFT, rand_sym());
    else if (pick < 70) send_op(OP_RIGHT, rand_sym());
    else if (pick < 85) send_op(OP_DELETE, rand_sym());
    else if (pick < 93) send_op(OP_DUMP, rand_sym());
    else send_op(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_sym());
  endtask

  // Overfill from any state so the last few inserts are dropped
  task automatic fill_text();
    repeat (CAPACITY_DEF + 3) send_op(OP_INSERT, rand_sym());
    send_op(OP_LEFT, rand_sym());
    send_op(OP_INSERT, rand_sym());
    send_op(OP_DUMP, rand_sym());
  endtask

  task automatic run_phase(input int count);
    int               start;
    int               pick;
    logic [OP_W-1:0]  dir;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        repeat ($urandom_range(4, 12)) send_random_op();
      end else if (pick < 65) begin
        dir = $urandom_range(0, 1) ? OP_LEFT : OP_RIGHT;
        repeat ($urandom_range(1, 20)) send_op(dir, rand_sym());
      end else if (pick < 78) begin
        send_op(OP_DUMP, rand_sym());
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 15)) send_op(OP_DELETE, rand_sym());
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 20)) send_op(OP_INSERT, rand_sym());
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_LEFT;
    in_symbol    <= '0;
    tx_idle_pct  = 10;
    rx_idle_pct  = 69;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty buffer: dump and every boundary case
    send_op(OP_DUMP, 8'h00);
    send_op(OP_LEFT, 8'h00);
    send_op(OP_RIGHT, 8'hFF);
    send_op(OP_DELETE, 8'h00);
    send_op(OP_INSERT, 8'h00);
    send_op(OP_INSERT, 8'hFF);
    send_op(OP_INSERT, 8'hA5);
    send_op(OP_INSERT, 8'h5A);
    send_op(OP_LEFT, 8'hFF);
    send_op(OP_LEFT, 8'h00);
    send_op(OP_DUMP, 8'hFF);
    send_op(OP_DELETE, 8'hFF);
    send_op(OP_RIGHT, 8'h00);
    send_op(OP_RIGHT, 8'h00);
    send_op(OP_RIGHT, 8'hFF);
    send_op(OP_DUMP, 8'h00);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send_op(OP_W'(c), 8'hFF);
    repeat (2) send_op(OP_LEFT, 8'h00);
    repeat (3) send_op(OP_DELETE, 8'h00);
    send_op(OP_DUMP, 8'h00);
    drain_results();

    fill_text();
    run_phase(PHASE_ITEMS);
    drain_results();

    tx_idle_pct = 69;
    rx_idle_pct = 10;
    run_phase(PHASE_ITEMS);
    drain_results();

    // Hold the result side while items keep coming, so the editor backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    fill_text();
    run_phase(PHASE_ITEMS);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d operations (%0d dumps) plus %0d undefined codes, %0d results checked,",
             items_sent, dumps_sent, spare_sent, results_checked);
    $display("across three stall mixes, a long result hold and full-buffer insert bursts.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: cursor_line_editor_buffer.f
src/cle_pkg.sv
src/cle_stack_ram.sv
src/cle_ctrl.sv
src/cursor_line_editor_buffer.sv
tb/sv/cursor_line_editor_scoreboard.sv
tb/sv/cursor_line_editor_buffer_test.sv
